FILE: design/sll_pkg.sv
// shared constants, types and codes for the stereo lookahead limiter
package sll_pkg;

    // delay line
    localparam int DELAY_DEPTH = 512;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);

    // field and register widths
    localparam int IN_W   = 24;
    localparam int OUT_W  = 28;
    localparam int IG_W   = 24;
    localparam int LIM_W  = 27;
    localparam int REL_W  = 24;
    localparam int DLY_W  = 9;
    localparam int GAIN_W = 24;
    localparam int FRAME_W = 2 * OUT_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = OUT_W;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // divider
    localparam int DIV_STEPS = 23;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // fixed-point constants
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h800000;
    localparam int SCALE_SH  = 20;
    localparam int OUT_SH    = 23;
    localparam int REL_SH    = 24;

    // reset values of the registers
    localparam logic [IG_W-1:0]  RST_INPUT_GAIN = 24'h100000;
    localparam logic [LIM_W-1:0] RST_LIMIT      = 27'h0800000;
    localparam logic [LIM_W-1:0] RST_CEILING    = 27'h0800000;
    localparam logic [REL_W-1:0] RST_RELEASE    = 24'd34953;
    localparam logic [DLY_W-1:0] RST_DELAY      = 9'd1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_INPUT_GAIN   = 3'd0;
    localparam t_cfg_idx REG_LIMIT_LEVEL  = 3'd1;
    localparam t_cfg_idx REG_CEILING      = 3'd2;
    localparam t_cfg_idx REG_RELEASE_STEP = 3'd3;
    localparam t_cfg_idx REG_DELAY_FRAMES = 3'd4;

    typedef logic signed [IN_W-1:0]  t_sample_in;
    typedef logic signed [OUT_W-1:0] t_sample_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCL_L,
        ST_SCL_R,
        ST_SAT_R,
        ST_PEAK,
        ST_CMP,
        ST_DIV,
        ST_GAIN,
        ST_REL,
        ST_MUL_L,
        ST_MUL_R,
        ST_DONE
    } t_state;

endpackage

FILE: design/sll_if.sv
// valid/ready channel interfaces for input frames, results and register writes

interface sll_in_if import sll_pkg::*; ();
    logic       valid;
    logic       ready;
    t_sample_in left_in;
    t_sample_in right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sll_out_if import sll_pkg::*; ();
    logic        valid;
    logic        ready;
    t_sample_out left_out;
    t_sample_out right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sll_cfg_if import sll_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/sll_ram.sv
// generic single-write, single-read RAM with registered read data
module sll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/stereo_lookahead_limiter_top.sv
// stereo lookahead peak limiter with linked channels, top level
//
//  channel  | dir | payload                         | accepted when
//  ---------+-----+---------------------------------+-------------------------
//  i_in     | in  | left_in, right_in  (Q1.23)      | i_in.valid & i_in.ready
//  o_out    | out | left_out, right_out (Q5.23)     | o_out.valid & o_out.ready
//  i_cfg    | in  | index, data (register write)    | i_cfg.valid & i_cfg.ready
//
// one item at a time: when the peak is above the limit the target gain is divided out
// (23 one-bit divider steps), and release is skipped on an attack; the next item is
// taken the cycle after the result is loaded, which waits out any output stall
// all multiplies share one 28x25 multiplier with a registered product
// i_rst_n is synchronous; the delay line reads as zero through a fill count
// i_in.ready is high only in idle; register writes are always taken
module stereo_lookahead_limiter_top import sll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sll_in_if.sink      i_in,
    sll_out_if.source   o_out,
    sll_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [IG_W-1:0]  r_input_gain;
    logic [LIM_W-1:0] r_limit;
    logic [LIM_W-1:0] r_ceiling;
    logic [REL_W-1:0] r_release;
    logic [DLY_W-1:0] r_delay;

    // sequencer
    t_state r_state, n_state;

    // delay line bookkeeping
    logic [ADDR_W-1:0] r_wi;
    logic [FILL_W-1:0] r_fill;
    logic              r_rd_valid;

    // datapath registers
    t_sample_in             r_left, r_right;
    t_sample_out            r_xl, r_xr;
    logic [OUT_W-1:0]       r_peak;
    logic [LIM_W:0]         r_rem;
    logic [DIV_STEPS-1:0]   r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic [GAIN_W-1:0]      r_tgt;
    logic [GAIN_W-1:0]      r_gain;
    logic signed [PROD_W-1:0] r_prod;
    t_sample_out            r_yl;

    // output register
    logic        r_out_valid;
    t_sample_out r_out_l, r_out_r;

    // combinational controls
    logic                      in_ready;
    logic                      in_fire;
    logic                      out_load;
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      ram_wr_en;

    // address generation
    logic [ADDR_W-1:0] d_eff;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wi_next;
    logic [FRAME_W-1:0] rd_data;
    t_sample_out        y_l, y_r;

    // arithmetic helpers
    logic [OUT_W-1:0]    mag_l, mag_r;
    logic [LIM_W+1:0]    rem2;
    logic [LIM_W+1:0]    rem_diff;
    logic                q_bit;
    logic                gain_drop;
    logic [PROD_W-1:0]   rel_sum;
    logic [GAIN_W-1:0]   rel_inc;

    // round, shift by the input-gain format and saturate to Q5.23
    function automatic t_sample_out sat_scale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        logic                     fits;
        v = (p + $signed(PROD_W'(1 << (SCALE_SH - 1)))) >>> SCALE_SH;
        fits = (v[PROD_W-1:OUT_W-1] == '0) || (v[PROD_W-1:OUT_W-1] == '1);
        if (fits) begin
            sat_scale = OUT_W'(v);
        end else if (v[PROD_W-1]) begin
            sat_scale = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat_scale = {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    // round the gain product and clamp to +/- ceiling
    function automatic t_sample_out clamp_out(input logic signed [PROD_W-1:0] p,
                                              input logic [LIM_W-1:0] c);
        logic signed [PROD_W-1:0] v;
        logic signed [PROD_W-1:0] cp;
        logic signed [PROD_W-1:0] cn;
        v  = (p + $signed(PROD_W'(1 << (OUT_SH - 1)))) >>> OUT_SH;
        cp = $signed(PROD_W'(c));
        cn = -cp;
        if (v > cp) begin
            clamp_out = OUT_W'(cp);
        end else if (v < cn) begin
            clamp_out = OUT_W'(cn);
        end else begin
            clamp_out = OUT_W'(v);
        end
    endfunction

    function automatic logic [OUT_W-1:0] magnitude(input t_sample_out x);
        magnitude = x[OUT_W-1] ? (~x + 1'b1) : x;
    endfunction

    // ---------------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------------
    assign i_in.ready  = in_ready;
    assign in_fire     = i_in.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

    // ---------------------------------------------------------------------
    // configuration writes, masked to each register's width
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain <= RST_INPUT_GAIN;
            r_limit      <= RST_LIMIT;
            r_ceiling    <= RST_CEILING;
            r_release    <= RST_RELEASE;
            r_delay      <= RST_DELAY;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_INPUT_GAIN:   r_input_gain <= i_cfg.data[IG_W-1:0];
                REG_LIMIT_LEVEL:  r_limit      <= i_cfg.data[LIM_W-1:0];
                REG_CEILING:      r_ceiling    <= i_cfg.data[LIM_W-1:0];
                REG_RELEASE_STEP: r_release    <= i_cfg.data[REL_W-1:0];
                REG_DELAY_FRAMES: r_delay      <= i_cfg.data[DLY_W-1:0];
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // delay line addressing
    // ---------------------------------------------------------------------
    // effective delay: zero acts as one, too large acts as depth - 1
    always_comb begin
        if (r_delay == '0) begin
            d_eff = ADDR_W'(1);
        end else if (32'(r_delay) >= 32'(DELAY_DEPTH)) begin
            d_eff = ADDR_W'(DELAY_DEPTH - 1);
        end else begin
            d_eff = ADDR_W'(r_delay);
        end
    end

    // read slot is write slot minus delay, wrapped at the depth
    assign rd_addr = (r_wi >= d_eff) ? (r_wi - d_eff)
                                     : (r_wi - d_eff + ADDR_W'(DELAY_DEPTH));
    assign wi_next = (r_wi == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : (r_wi + 1'b1);

    sll_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wi),
        .i_wr_data ({r_xl, r_xr}),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // slots not yet written since reset read as silence
    assign y_l = r_rd_valid ? rd_data[FRAME_W-1:OUT_W] : '0;
    assign y_r = r_rd_valid ? rd_data[OUT_W-1:0]       : '0;

    // ---------------------------------------------------------------------
    // shared multiplier
    // ---------------------------------------------------------------------
    assign mul_p = mul_a * mul_b;

    // ---------------------------------------------------------------------
    // arithmetic helpers
    // ---------------------------------------------------------------------
    assign mag_l = magnitude(r_xl);
    assign mag_r = magnitude(r_xr);

    // restoring divider step: limit * 2^23 / peak, one quotient bit a cycle
    assign rem2     = {r_rem, 1'b0};
    assign rem_diff = rem2 - {1'b0, r_peak};
    assign q_bit    = (rem2 >= {1'b0, r_peak});

    assign gain_drop = (r_tgt < r_gain);

    // recovery increment rounds up so the gain reaches unity exactly
    assign rel_sum = $unsigned(r_prod) + PROD_W'((1 << REL_SH) - 1);
    assign rel_inc = rel_sum[REL_SH+GAIN_W-1:REL_SH];

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in.valid) n_state = ST_SCL_L;
            ST_SCL_L: n_state = ST_SCL_R;
            ST_SCL_R: n_state = ST_SAT_R;
            ST_SAT_R: n_state = ST_PEAK;
            ST_PEAK:  n_state = ST_CMP;
            ST_CMP: begin
                if (r_peak > {1'b0, r_limit}) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_GAIN;
                end
            end
            ST_DIV:   if (r_cnt == '0) n_state = ST_GAIN;
            ST_GAIN:  n_state = gain_drop ? ST_MUL_L : ST_REL;
            ST_REL:   n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_DONE;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer outputs
    // ---------------------------------------------------------------------
    always_comb begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        ram_wr_en = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_SCL_L: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(r_left);
                mul_b  = $signed({1'b0, r_input_gain});
            end
            ST_SCL_R: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(r_right);
                mul_b  = $signed({1'b0, r_input_gain});
            end
            ST_PEAK: ram_wr_en = 1'b1;
            ST_GAIN: begin
                // remaining distance to unity times the release fraction
                mul_en = !gain_drop;
                mul_a  = $signed(MUL_A_W'(UNITY_GAIN - r_gain));
                mul_b  = $signed({1'b0, r_release});
            end
            ST_MUL_L: begin
                mul_en = 1'b1;
                mul_a  = y_l;
                mul_b  = $signed({1'b0, r_gain});
            end
            ST_MUL_R: begin
                mul_en = 1'b1;
                mul_a  = y_r;
                mul_b  = $signed({1'b0, r_gain});
            end
            ST_DONE: out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wi        <= '0;
            r_fill      <= '0;
            r_gain      <= UNITY_GAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_wr_en) begin
                r_wi <= wi_next;
                if (r_fill != FILL_W'(DELAY_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == ST_GAIN && gain_drop) begin
                r_gain <= r_tgt;            // attack: take the lower target at once
            end else if (r_state == ST_REL) begin
                r_gain <= r_gain + rel_inc; // release toward unity
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        if (in_fire) begin
            r_left     <= i_in.left_in;
            r_right    <= i_in.right_in;
            r_rd_valid <= (FILL_W'(rd_addr) < r_fill);
        end
        unique case (r_state)
            ST_SCL_R: r_xl <= sat_scale(r_prod);
            ST_SAT_R: r_xr <= sat_scale(r_prod);
            ST_PEAK:  r_peak <= (mag_l > mag_r) ? mag_l : mag_r;
            ST_CMP: begin
                // divider setup; limit below peak keeps the quotient under unity
                r_rem <= {1'b0, r_limit};
                r_quo <= '0;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
                r_tgt <= UNITY_GAIN;
            end
            ST_DIV: begin
                r_rem <= q_bit ? rem_diff[LIM_W:0] : rem2[LIM_W:0];
                r_quo <= {r_quo[DIV_STEPS-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_tgt <= GAIN_W'({r_quo[DIV_STEPS-2:0], q_bit});
                end
            end
            ST_MUL_R: r_yl <= clamp_out(r_prod, r_ceiling);
            ST_DONE: begin
                if (out_load) begin
                    r_out_l <= r_yl;
                    r_out_r <= clamp_out(r_prod, r_ceiling);
                end
            end
            default: ;
        endcase
    end

endmodule
